/* hdl/dts_pkg.sv */
// Shared constants, payload structs and register codes for the disc timestamp stamper.
`timescale 1ns / 1ps

package dts_pkg;

    // Default geometry
    localparam int DEF_MAP_ROWS   = 64;
    localparam int DEF_MAP_COLS   = 64;
    localparam int DEF_MAX_RADIUS = 15;

    // Field widths
    localparam int COORD_W = 6;
    localparam int RAD_W   = 4;
    localparam int TIME_W  = 31;
    localparam int COUNT_W = 10;
    localparam int DIM_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register map (index taken from paddr[2])
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 7'd64;

    // Command modes
    localparam logic MODE_STAMP = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic               map_select;
        logic [COORD_W-1:0] center_col;
        logic [COORD_W-1:0] center_row;
        logic [RAD_W-1:0]   radius;
        logic [TIME_W-1:0]  stamp_time;
    } dts_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cells_written;
        logic [TIME_W-1:0]  stored_time;
    } dts_rsp_t;

endpackage

/* hdl/dts_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module dts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/disc_timestamp_stamper.sv */
// Top level of the disc timestamp stamper: command decode, disc scan and store access.
`timescale 1ns / 1ps

// Two grids of 31-bit timestamps live in one single-port RAM of
// 2*MAP_ROWS*MAP_COLS words. After reset the block runs a clearing pass that
// writes zero to every word, one word per cycle; busy stays high throughout
// and only configuration writes are taken. A command is taken when start is
// high and busy is low. A stamp walks the disc's bounding square, clipped to
// the map in use, one cell per cycle through the RAM write port, so busy stays
// high for the whole clipped square, and the result strobe done follows in the
// cycle after the last cell. A stamp whose square falls entirely off the map
// reports zero on the cycle after the transfer. A read sends the address to
// the RAM in the transfer cycle, takes the registered data in the read state
// and then registers it onto rsp. The result is on rsp for exactly one cycle
// with done high; there is no back-pressure, so the receiver must take it
// then. A new command may be started in the same cycle done is shown.
// map_width/map_height sit at byte addresses 0 and 4 and must only be
// written while the block is idle.
module disc_timestamp_stamper
    import dts_pkg::*;
#(
    parameter int MAP_ROWS   = DEF_MAP_ROWS,
    parameter int MAP_COLS   = DEF_MAP_COLS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic               clk,
    input  logic               rst_n,

    // Command / result
    input  logic               start,
    output logic               busy,
    input  dts_cmd_t           cmd,
    output logic               done,
    output dts_rsp_t           rsp,

    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH  = 2 * MAP_ROWS * MAP_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SCAN_W = DIM_W;   // clipped coordinates stay below 127
    localparam int SGN_W  = 9;       // signed bound math: -15 .. 78
    localparam int SQ_W   = 2 * RAD_W;

    localparam logic [ADDR_W-1:0] GRID_BASE = ADDR_W'(MAP_ROWS * MAP_COLS);
    localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(MAP_COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_STAMP = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] map_height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAP_WIDTH:  map_width_reg  <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAP_WIDTH:  prdata = PDATA_W'(map_width_reg);
            REG_MAP_HEIGHT: prdata = PDATA_W'(map_height_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective map size and radius
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] w_use;
    logic [DIM_W-1:0] h_use;
    logic [RAD_W-1:0] rad_eff;

    assign w_use = (11'(map_width_reg) < 11'(MAP_COLS))  ? map_width_reg  : DIM_W'(MAP_COLS);
    assign h_use = (11'(map_height_reg) < 11'(MAP_ROWS)) ? map_height_reg : DIM_W'(MAP_ROWS);
    assign rad_eff = (9'(cmd.radius) > 9'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cmd.radius;

    // Clipped bounding square of the incoming disc
    logic signed [SGN_W-1:0] row_lo, row_hi, col_lo, col_hi;
    logic signed [SGN_W-1:0] row_lo_c, row_hi_c, col_lo_c, col_hi_c;
    logic signed [SGN_W-1:0] h_m1, w_m1;
    logic                    box_empty;
    logic                    read_on_map;

    always_comb
    begin
        row_lo = $signed(SGN_W'(cmd.center_row)) - $signed(SGN_W'(rad_eff));
        row_hi = $signed(SGN_W'(cmd.center_row)) + $signed(SGN_W'(rad_eff));
        col_lo = $signed(SGN_W'(cmd.center_col)) - $signed(SGN_W'(rad_eff));
        col_hi = $signed(SGN_W'(cmd.center_col)) + $signed(SGN_W'(rad_eff));
        h_m1   = $signed(SGN_W'(h_use)) - 9'sd1;
        w_m1   = $signed(SGN_W'(w_use)) - 9'sd1;

        row_lo_c = row_lo[SGN_W-1] ? 9'sd0 : row_lo;
        col_lo_c = col_lo[SGN_W-1] ? 9'sd0 : col_lo;
        row_hi_c = (row_hi > h_m1) ? h_m1 : row_hi;
        col_hi_c = (col_hi > w_m1) ? w_m1 : col_hi;

        box_empty = (row_hi_c < row_lo_c) || (col_hi_c < col_lo_c);
    end

    assign read_on_map = ({1'b0, cmd.center_col} < w_use) &&
                         ({1'b0, cmd.center_row} < h_use);

    // ------------------------------------------------------------------
    // Scan registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               sel_reg, sel_next;
    logic [COORD_W-1:0] crow_reg, crow_next;
    logic [COORD_W-1:0] ccol_reg, ccol_next;
    logic [SQ_W-1:0]    rad_sq_reg, rad_sq_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [SCAN_W-1:0]  row_reg, row_next;
    logic [SCAN_W-1:0]  col_reg, col_next;
    logic [SCAN_W-1:0]  c0_reg, c0_next;
    logic [SCAN_W-1:0]  r1_reg, r1_next;
    logic [SCAN_W-1:0]  c1_reg, c1_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    dts_rsp_t           rsp_reg, rsp_next;

    // Distance test for the current scan cell
    logic signed [SGN_W-1:0] dy_full, dx_full;
    logic signed [RAD_W:0]   dy, dx;
    logic signed [9:0]       dy_sq, dx_sq;
    logic [9:0]              dist_sq;
    logic                    in_disc;
    logic [COUNT_W-1:0]      count_inc;

    assign dy_full = $signed(SGN_W'(row_reg)) - $signed(SGN_W'(crow_reg));
    assign dx_full = $signed(SGN_W'(col_reg)) - $signed(SGN_W'(ccol_reg));
    assign dy      = dy_full[RAD_W:0];
    assign dx      = dx_full[RAD_W:0];
    assign dy_sq   = 10'(dy) * 10'(dy);
    assign dx_sq   = 10'(dx) * 10'(dx);
    assign dist_sq = $unsigned(dy_sq) + $unsigned(dx_sq);
    assign in_disc = dist_sq <= 10'(rad_sq_reg);

    // saturating count of written cells
    assign count_inc = !in_disc ? count_reg :
                       (count_reg == '1) ? count_reg : count_reg + 1'b1;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic              sel,
        input logic [SCAN_W-1:0] row,
        input logic [SCAN_W-1:0] col
    );
        logic [ADDR_W-1:0] base;
        base = sel ? GRID_BASE : '0;
        return base + ADDR_W'(row) * COL_STEP + ADDR_W'(col);
    endfunction

    // RAM access
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [TIME_W-1:0] ram_wdata;
    logic [TIME_W-1:0] ram_rdata;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        sel_next     = sel_reg;
        crow_next    = crow_reg;
        ccol_next    = ccol_reg;
        rad_sq_next  = rad_sq_reg;
        time_next    = time_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        c0_next      = c0_reg;
        r1_next      = r1_reg;
        c1_next      = c1_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;

        ram_we    = 1'b0;
        ram_addr  = cell_addr(sel_reg, row_reg, col_reg);
        ram_wdata = time_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == MODE_READ)
                    begin
                        if (read_on_map)
                        begin
                            ram_addr   = cell_addr(cmd.map_select,
                                                   SCAN_W'(cmd.center_row),
                                                   SCAN_W'(cmd.center_col));
                            state_next = ST_READ;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    end
                    else if (box_empty)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                    else
                    begin
                        sel_next    = cmd.map_select;
                        crow_next   = cmd.center_row;
                        ccol_next   = cmd.center_col;
                        rad_sq_next = SQ_W'(rad_eff) * SQ_W'(rad_eff);
                        time_next   = cmd.stamp_time;
                        row_next    = row_lo_c[SCAN_W-1:0];
                        col_next    = col_lo_c[SCAN_W-1:0];
                        c0_next     = col_lo_c[SCAN_W-1:0];
                        r1_next     = row_hi_c[SCAN_W-1:0];
                        c1_next     = col_hi_c[SCAN_W-1:0];
                        count_next  = '0;
                        state_next  = ST_STAMP;
                    end
                end
            end

            ST_STAMP:
            begin
                ram_we     = in_disc;
                count_next = count_inc;
                if (col_reg == c1_reg)
                begin
                    col_next = c0_reg;
                    if (row_reg == r1_reg)
                    begin
                        done_next              = 1'b1;
                        rsp_next.cells_written = count_inc;
                        rsp_next.stored_time   = '0;
                        state_next             = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                done_next              = 1'b1;
                rsp_next.cells_written = '0;
                rsp_next.stored_time   = ram_rdata;
                state_next             = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        crow_reg   <= crow_next;
        ccol_reg   <= ccol_next;
        rad_sq_reg <= rad_sq_next;
        time_reg   <= time_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        c0_reg     <= c0_next;
        r1_reg     <= r1_next;
        c1_reg     <= c1_next;
        count_reg  <= count_next;
        rsp_reg    <= rsp_next;
    end

    dts_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // store is only written by the clearing pass or a stamp scan
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_STAMP))
        else $error("store written outside clear or stamp");

    // scan position never passes the last row or leaves the column bounds of the square
    a_scan_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STAMP) |->
            (row_reg <= r1_reg && col_reg <= c1_reg && col_reg >= c0_reg))
        else $error("scan outside bounding square");

    // a result carries either a count or a time, never both
    a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.cells_written == '0 || rsp.stored_time == '0))
        else $error("result has both count and time");

    // no result while the clearing pass runs
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != ST_CLEAR))
        else $error("result during clearing pass");

    // a read result always follows the read wait cycle
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> done)
        else $error("read finished without result");

endmodule
